// ----- sv/stick_deadzone_response_curve_assert.svh -----
// assertion macros shared by the stick deadzone checker
`ifndef STICK_DEADZONE_RESPONSE_CURVE_ASSERT_SVH
`define STICK_DEADZONE_RESPONSE_CURVE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SDRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sdrc_pkg.sv -----
// shared types and constants for the stick deadzone and response curve block
package sdrc_pkg;

	// field widths
	localparam int AXIS_W = 16;
	localparam int TRIG_W = 8;
	localparam int DZ_W = 15;
	localparam int MAG_W = 15;
	localparam int SQ_W = 2 * MAG_W;
	localparam int CUBE_W = 3 * MAG_W;
	// numerator carries the extra factor of full scale (15 bits)
	localparam int NUM_W = CUBE_W + MAG_W;
	// quotient is always below full scale when the divider is used
	localparam int Q_W = MAG_W;

	// pipeline shape: prepare, square, cube, scale, then one quotient bit per stage
	localparam int PREP_STAGES = 4;
	localparam int LANE_DEPTH = PREP_STAGES + Q_W;

	// register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [MAG_W-1:0] FULL_SCALE = 15'h7fff;
	localparam logic signed [AXIS_W-1:0] CURVE_POS = 16'sh7fff;
	localparam logic signed [AXIS_W-1:0] CURVE_NEG = 16'sh8001;
	localparam logic [DZ_W-1:0] LEFT_DZ_RESET = 15'd7849;
	localparam logic [DZ_W-1:0] RIGHT_DZ_RESET = 15'd8689;

	// register map, word index
	typedef enum logic [1:0] {
		REG_LINEAR_MODE,
		REG_SINGLE_STICK,
		REG_LEFT_DZ,
		REG_RIGHT_DZ
	} sdrc_reg_t;

	// one input sample
	typedef struct packed {
		logic signed [AXIS_W-1:0] left_axis;
		logic signed [AXIS_W-1:0] right_axis;
		logic [TRIG_W-1:0] left_trigger;
		logic [TRIG_W-1:0] right_trigger;
	} sdrc_in_t;

	// one result
	typedef struct packed {
		logic signed [AXIS_W-1:0] wheel;
		logic [AXIS_W-1:0] accel;
		logic [AXIS_W-1:0] brake;
	} sdrc_out_t;

	// per-stick settings handed to a lane
	typedef struct packed {
		logic linear_mode;
		logic [DZ_W-1:0] deadzone;
	} sdrc_lane_cfg_t;

endpackage

// ----- sv/sdrc_lane.sv -----
// one stick lane: deadzone, cube and pipelined restoring divide
module sdrc_lane (
	input logic clk,
	input logic [sdrc_pkg::LANE_DEPTH-1:0] ld,
	input sdrc_pkg::sdrc_lane_cfg_t cfg,
	input logic signed [sdrc_pkg::AXIS_W-1:0] axis,
	output logic signed [sdrc_pkg::AXIS_W-1:0] res
);
	import sdrc_pkg::*;

	// stage 1 combinational signals
	logic neg_c;
	logic [AXIS_W-1:0] mag_c;
	logic [AXIS_W-1:0] dz_c;
	logic signed [AXIS_W:0] v_x;
	logic signed [AXIS_W:0] d_x;
	logic signed [AXIS_W-1:0] lin_c;
	logic fixed_c;
	logic signed [AXIS_W-1:0] fval_c;
	logic [MAG_W-1:0] n_c;
	logic [MAG_W-1:0] d_c;

	// pipeline registers
	logic fixed_s1, fixed_s2, fixed_s3, fixed_s4;
	logic neg_s1, neg_s2, neg_s3, neg_s4;
	logic signed [AXIS_W-1:0] fval_s1, fval_s2, fval_s3, fval_s4;
	logic [MAG_W-1:0] n_s1, n_s2;
	logic [MAG_W-1:0] d_s1, d_s2;
	logic [SQ_W-1:0] nsq_s2, dsq_s2;
	logic [CUBE_W-1:0] ncube_s3, dcube_s3;
	logic [NUM_W-1:0] num_s4;
	logic [CUBE_W-1:0] den_s4;

	// divider stages
	logic [NUM_W-1:0] div_rem_s [Q_W];
	logic [CUBE_W-1:0] div_den_s [Q_W];
	logic [Q_W-1:0] div_q_s [Q_W];
	logic div_fixed_s [Q_W];
	logic div_neg_s [Q_W];
	logic signed [AXIS_W-1:0] div_fval_s [Q_W];

	// divider next values
	logic [NUM_W-1:0] rem_in [Q_W];
	logic [CUBE_W-1:0] den_in [Q_W];
	logic [Q_W-1:0] q_in [Q_W];
	logic [NUM_W-1:0] trial [Q_W];
	logic [NUM_W-1:0] rem_d [Q_W];
	logic [Q_W-1:0] q_d [Q_W];

	logic [AXIS_W-1:0] q_out;

	// magnitude, linear deadzone and curve short cuts
	always_comb begin
		neg_c = axis[AXIS_W-1];
		mag_c = neg_c ? (~$unsigned(axis) + AXIS_W'(1)) : $unsigned(axis);
		dz_c = AXIS_W'(cfg.deadzone);
		v_x = {axis[AXIS_W-1], axis};
		d_x = $signed({2'b00, cfg.deadzone});
		if (v_x < -d_x) begin
			lin_c = AXIS_W'(v_x + d_x);
		end else if (v_x > d_x) begin
			lin_c = AXIS_W'(v_x - d_x);
		end else begin
			lin_c = '0;
		end
		n_c = MAG_W'(mag_c - dz_c);
		d_c = FULL_SCALE - cfg.deadzone;
		if (cfg.linear_mode) begin
			fixed_c = 1'b1;
			fval_c = lin_c;
		end else if (mag_c <= dz_c) begin
			fixed_c = 1'b1;
			fval_c = '0;
		end else if (mag_c >= AXIS_W'(FULL_SCALE)) begin
			// at or beyond full scale: saturate
			fixed_c = 1'b1;
			fval_c = neg_c ? CURVE_NEG : CURVE_POS;
		end else begin
			fixed_c = 1'b0;
			fval_c = '0;
		end
	end

	// stage 1: capture prepared operands
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			fixed_s1 <= fixed_c;
			fval_s1 <= fval_c;
			neg_s1 <= neg_c;
			n_s1 <= n_c;
			d_s1 <= d_c;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			fixed_s2 <= fixed_s1;
			fval_s2 <= fval_s1;
			neg_s2 <= neg_s1;
			n_s2 <= n_s1;
			d_s2 <= d_s1;
			nsq_s2 <= SQ_W'(n_s1) * SQ_W'(n_s1);
			dsq_s2 <= SQ_W'(d_s1) * SQ_W'(d_s1);
		end
	end

	// stage 3: cubes
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			fixed_s3 <= fixed_s2;
			fval_s3 <= fval_s2;
			neg_s3 <= neg_s2;
			ncube_s3 <= CUBE_W'(nsq_s2) * CUBE_W'(n_s2);
			dcube_s3 <= CUBE_W'(dsq_s2) * CUBE_W'(d_s2);
		end
	end

	// stage 4: numerator times full scale as shift and subtract
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			fixed_s4 <= fixed_s3;
			fval_s4 <= fval_s3;
			neg_s4 <= neg_s3;
			num_s4 <= (NUM_W'(ncube_s3) << MAG_W) - NUM_W'(ncube_s3);
			den_s4 <= dcube_s3;
		end
	end

	// restoring divide, most significant quotient bit first
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				rem_in[k] = num_s4;
				den_in[k] = den_s4;
				q_in[k] = '0;
			end else begin
				rem_in[k] = div_rem_s[k-1];
				den_in[k] = div_den_s[k-1];
				q_in[k] = div_q_s[k-1];
			end
			trial[k] = NUM_W'(den_in[k]) << (Q_W - 1 - k);
			if (rem_in[k] >= trial[k]) begin
				rem_d[k] = rem_in[k] - trial[k];
				q_d[k] = q_in[k] | (Q_W'(1) << (Q_W - 1 - k));
			end else begin
				rem_d[k] = rem_in[k];
				q_d[k] = q_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < Q_W; k++) begin
			if (ld[PREP_STAGES + k]) begin
				div_rem_s[k] <= rem_d[k];
				div_den_s[k] <= den_in[k];
				div_q_s[k] <= q_d[k];
				if (k == 0) begin
					div_fixed_s[k] <= fixed_s4;
					div_neg_s[k] <= neg_s4;
					div_fval_s[k] <= fval_s4;
				end else begin
					div_fixed_s[k] <= div_fixed_s[k-1];
					div_neg_s[k] <= div_neg_s[k-1];
					div_fval_s[k] <= div_fval_s[k-1];
				end
			end
		end
	end

	// apply sign or pick the short-cut value
	always_comb begin
		q_out = AXIS_W'(div_q_s[Q_W-1]);
		if (div_fixed_s[Q_W-1]) begin
			res = div_fval_s[Q_W-1];
		end else if (div_neg_s[Q_W-1]) begin
			res = $signed(AXIS_W'(0) - q_out);
		end else begin
			res = $signed(q_out);
		end
	end

endmodule

// ----- sv/stick_deadzone_response_curve.sv -----
// top level: register port, pipeline control and wheel combining
// Conditions one controller sample per transaction: each stick's deadzone is
// removed and, in curve mode, the remainder is shaped by an exact cubic
// (32767 * (|v|-d)^3 / (32767-d)^3, clamped); the wheel is the left stick or
// the average of both sticks, and each trigger comes out shifted left by 8.
// A new sample is taken every clock cycle while the pipeline does not stall; each
// sample passes through 4 stages for the deadzone, squares, cubes and scaling,
// 15 stages of a restoring divider that settles one quotient bit per stage, and
// the output register. Pipeline stages that hold no sample close up under stall,
// so samples keep entering until every stage is full. Registers are written
// through the APB-style port at byte addresses 0, 4, 8 and 12 and should only
// change while no sample is in flight.
module stick_deadzone_response_curve (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input sdrc_pkg::sdrc_in_t sample,
	output logic result_valid,
	input logic result_stall,
	output sdrc_pkg::sdrc_out_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sdrc_pkg::ADDR_W-1:0] paddr,
	input logic [sdrc_pkg::DATA_W-1:0] pwdata,
	output logic [sdrc_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import sdrc_pkg::*;

	// configuration registers
	logic linear_mode_q;
	logic single_stick_q;
	logic [DZ_W-1:0] left_dz_q;
	logic [DZ_W-1:0] right_dz_q;
	sdrc_reg_t reg_idx;

	// pipeline control
	logic [LANE_DEPTH:0] ld;
	logic vld_s [LANE_DEPTH];
	logic [TRIG_W-1:0] ltrig_s [LANE_DEPTH];
	logic [TRIG_W-1:0] rtrig_s [LANE_DEPTH];

	sdrc_lane_cfg_t left_cfg;
	sdrc_lane_cfg_t right_cfg;
	logic signed [AXIS_W-1:0] left_res;
	logic signed [AXIS_W-1:0] right_res;
	logic signed [AXIS_W:0] sum;
	logic signed [AXIS_W:0] sum_adj;
	logic signed [AXIS_W-1:0] wheel_c;

	logic result_vld_q;
	sdrc_out_t result_q;

	assign reg_idx = sdrc_reg_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_mode_q <= 1'b0;
			single_stick_q <= 1'b0;
			left_dz_q <= LEFT_DZ_RESET;
			right_dz_q <= RIGHT_DZ_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_LINEAR_MODE: linear_mode_q <= pwdata[0];
				REG_SINGLE_STICK: single_stick_q <= pwdata[0];
				REG_LEFT_DZ: left_dz_q <= pwdata[DZ_W-1:0];
				REG_RIGHT_DZ: right_dz_q <= pwdata[DZ_W-1:0];
				default: ;
			endcase
		end
	end

	// register read mux
	always_comb begin
		case (reg_idx)
			REG_LINEAR_MODE: prdata = DATA_W'(linear_mode_q);
			REG_SINGLE_STICK: prdata = DATA_W'(single_stick_q);
			REG_LEFT_DZ: prdata = DATA_W'(left_dz_q);
			REG_RIGHT_DZ: prdata = DATA_W'(right_dz_q);
			default: prdata = '0;
		endcase
	end

	// a stage loads when it is empty or the stage after it loads
	assign ld[LANE_DEPTH] = !result_vld_q || !result_stall;
	for (genvar i = 0; i < LANE_DEPTH; i++) begin : g_ld
		assign ld[i] = !vld_s[i] || ld[i+1];
	end
	assign sample_stall = !ld[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < LANE_DEPTH; i++) begin
				if (ld[i]) begin
					vld_s[i] <= (i == 0) ? sample_valid : vld_s[i-1];
				end
			end
		end
	end

	// triggers ride alongside the stick lanes
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANE_DEPTH; i++) begin
			if (ld[i]) begin
				if (i == 0) begin
					ltrig_s[i] <= sample.left_trigger;
					rtrig_s[i] <= sample.right_trigger;
				end else begin
					ltrig_s[i] <= ltrig_s[i-1];
					rtrig_s[i] <= rtrig_s[i-1];
				end
			end
		end
	end

	assign left_cfg = '{linear_mode: linear_mode_q, deadzone: left_dz_q};
	assign right_cfg = '{linear_mode: linear_mode_q, deadzone: right_dz_q};

	sdrc_lane u_left (
		.clk (clk),
		.ld (ld[LANE_DEPTH-1:0]),
		.cfg (left_cfg),
		.axis (sample.left_axis),
		.res (left_res)
	);

	sdrc_lane u_right (
		.clk (clk),
		.ld (ld[LANE_DEPTH-1:0]),
		.cfg (right_cfg),
		.axis (sample.right_axis),
		.res (right_res)
	);

	// average of both sticks, truncated toward zero
	always_comb begin
		sum = {left_res[AXIS_W-1], left_res} + {right_res[AXIS_W-1], right_res};
		sum_adj = sum + $signed({{AXIS_W{1'b0}}, sum[AXIS_W]});
		wheel_c = single_stick_q ? left_res : sum_adj[AXIS_W:1];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (ld[LANE_DEPTH]) begin
			result_vld_q <= vld_s[LANE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[LANE_DEPTH]) begin
			result_q.wheel <= wheel_c;
			result_q.accel <= {rtrig_s[LANE_DEPTH-1], {(AXIS_W-TRIG_W){1'b0}}};
			result_q.brake <= {ltrig_s[LANE_DEPTH-1], {(AXIS_W-TRIG_W){1'b0}}};
		end
	end

	assign result_valid = result_vld_q;
	assign result = result_q;

endmodule

// ----- sv/sdrc_checker.sv -----
// port-level checker for the stick deadzone block and its bind
`include "stick_deadzone_response_curve_assert.svh"

module sdrc_checker (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input sdrc_pkg::sdrc_in_t sample,
	input logic result_valid,
	input logic result_stall,
	input sdrc_pkg::sdrc_out_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sdrc_pkg::ADDR_W-1:0] paddr,
	input logic [sdrc_pkg::DATA_W-1:0] pwdata,
	input logic [sdrc_pkg::DATA_W-1:0] prdata,
	input logic pready
);
	import sdrc_pkg::*;

	// a stalled result transaction holds its value
	`SDRC_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// input only backs up when the output is backed up
	`SDRC_ASSERT_NOW(a_stall_cause, sample_stall, result_valid && result_stall, "input stalled while output free")

	// trigger outputs keep a clear low byte
	`SDRC_ASSERT_NOW(a_trig_shift, result_valid, result.accel[7:0] == 8'd0 && result.brake[7:0] == 8'd0, "trigger low byte not zero")

	// mode register reads back a single bit
	`SDRC_ASSERT_NOW(a_mode_width, psel && !pwrite && paddr[ADDR_W-1:2] == REG_LINEAR_MODE, prdata[DATA_W-1:1] == '0, "mode readback too wide")

	// a written deadzone reads back right away
	`SDRC_ASSERT_NEXT(a_dz_readback, psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_LEFT_DZ, !(psel && !pwrite && paddr[ADDR_W-1:2] == REG_LEFT_DZ) || prdata[DZ_W-1:0] == $past(pwdata[DZ_W-1:0]), "deadzone readback mismatch")

endmodule

bind stick_deadzone_response_curve sdrc_checker u_sdrc_checker (.*);

// ----- sim/tb.sv -----
// testbench for the stick deadzone and response curve block
module tb;
	import sdrc_pkg::*;

	localparam longint unsigned FULL = FULL_SCALE;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 10;
	localparam int PHASE_SAMPLES = 175;
	localparam int N_DIRECTED = 25;

	// one directed row: register settings, the sample, and a typed wheel where obvious
	typedef struct packed {
		bit lin;
		bit single;
		logic [DZ_W-1:0] ldz;
		logic [DZ_W-1:0] rdz;
		logic signed [AXIS_W-1:0] left;
		logic signed [AXIS_W-1:0] right;
		logic [TRIG_W-1:0] ltrig;
		logic [TRIG_W-1:0] rtrig;
		bit known;
		logic signed [AXIS_W-1:0] wheel;
	} stick_case_t;

	stick_case_t stick_cases [N_DIRECTED] = '{
		// reset settings: curve mode, averaged sticks
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd0, 16'sd0, 8'd0, 8'd0, 1'b1, 16'sd0},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd32767, 16'sd32767, 8'd255, 8'd255, 1'b1,
			16'sd32767},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, -16'sd32768, -16'sd32768, 8'd0, 8'd255, 1'b1,
			-16'sd32767},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd7849, -16'sd8689, 8'd128, 8'd1, 1'b1, 16'sd0},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, -16'sd7848, 16'sd8688, 8'd1, 8'd128, 1'b1, 16'sd0},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd7850, -16'sd8690, 8'd85, 8'd170, 1'b0, 16'sd0},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd20000, -16'sd12345, 8'd170, 8'd85, 1'b0,
			16'sd0},
		'{1'b0, 1'b0, 15'd7849, 15'd8689, 16'sd32767, 16'sd0, 8'd15, 8'd240, 1'b1,
			16'sd16383},
		'{1'b0, 1'b1, 15'd7849, 15'd8689, -16'sd32768, 16'sd32767, 8'd240, 8'd15, 1'b1,
			-16'sd32767},
		'{1'b0, 1'b1, 15'd7849, 15'd8689, 16'sd16000, 16'sd0, 8'd1, 8'd2, 1'b0, 16'sd0},
		// deadzone at full scale: divisor vanishes
		'{1'b0, 1'b0, 15'd32767, 15'd32767, -16'sd32768, 16'sd32767, 8'd3, 8'd4, 1'b1,
			-16'sd16383},
		'{1'b0, 1'b0, 15'd32767, 15'd32767, 16'sd32767, -16'sd32767, 8'd5, 8'd6, 1'b1,
			16'sd0},
		'{1'b0, 1'b1, 15'd32767, 15'd32767, 16'sd32767, 16'sd0, 8'd7, 8'd8, 1'b1, 16'sd0},
		// zero deadzone and a near-full one, curve overshoot
		'{1'b0, 1'b0, 15'd0, 15'd0, 16'sd32767, -16'sd32767, 8'd9, 8'd10, 1'b1, 16'sd0},
		'{1'b0, 1'b0, 15'd0, 15'd0, 16'sd1, 16'sd1, 8'd11, 8'd12, 1'b0, 16'sd0},
		'{1'b0, 1'b0, 15'd0, 15'd0, -16'sd32768, 16'sd0, 8'd13, 8'd14, 1'b1, -16'sd16383},
		'{1'b0, 1'b0, 15'd32766, 15'd32766, 16'sd32767, -16'sd32768, 8'd16, 8'd17, 1'b1,
			16'sd0},
		// linear mode, including the unclamped extreme
		'{1'b1, 1'b1, 15'd0, 15'd0, -16'sd32768, 16'sd0, 8'd255, 8'd0, 1'b1, -16'sd32768},
		'{1'b1, 1'b0, 15'd0, 15'd0, 16'sd32767, 16'sd32767, 8'd0, 8'd0, 1'b1, 16'sd32767},
		'{1'b1, 1'b0, 15'd0, 15'd0, -16'sd32768, -16'sd32768, 8'd255, 8'd255, 1'b1,
			-16'sd32768},
		'{1'b1, 1'b0, 15'd7849, 15'd8689, 16'sd7849, -16'sd8689, 8'd64, 8'd32, 1'b1, 16'sd0},
		'{1'b1, 1'b0, 15'd7849, 15'd8689, 16'sd7850, -16'sd8690, 8'd32, 8'd64, 1'b1, 16'sd0},
		'{1'b1, 1'b0, 15'd100, 15'd200, 16'sd1000, 16'sd2001, 8'd99, 8'd100, 1'b0, 16'sd0},
		'{1'b1, 1'b0, 15'd100, 15'd200, -16'sd1000, 16'sd3, 8'd200, 8'd201, 1'b0, 16'sd0},
		'{1'b1, 1'b1, 15'd32766, 15'd32767, -16'sd32768, 16'sd32767, 8'd127, 8'd254, 1'b1,
			-16'sd2}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sdrc_in_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	sdrc_out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// local copy of the register settings
	bit linear_on = 1'b0;
	bit single_on = 1'b0;
	logic [DZ_W-1:0] left_dz = LEFT_DZ_RESET;
	logic [DZ_W-1:0] right_dz = RIGHT_DZ_RESET;

	sdrc_out_t pending_results [$];
	sdrc_out_t want;
	bit gaps_on = 1'b0;
	int stall_left = 0;
	int errors = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int cycles = 0;

	stick_deadzone_response_curve dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// deadzone removal and response shaping of one stick
	function automatic int shape_axis(logic signed [AXIS_W-1:0] v, logic [DZ_W-1:0] dz,
			bit lin);
		int sv;
		int d;
		longint unsigned mag;
		longint unsigned rest;
		longint unsigned den;
		longint unsigned q;
		sv = v;
		d = dz;
		if (lin) begin
			if (sv < -d)
				return sv + d;
			if (sv > d)
				return sv - d;
			return 0;
		end
		mag = (sv < 0) ? -sv : sv;
		if (mag <= d)
			return 0;
		rest = mag - d;
		if (d >= FULL) begin
			q = FULL;
		end else begin
			den = FULL - d;
			q = (FULL * rest * rest * rest) / (den * den * den);
			if (q > FULL)
				q = FULL;
		end
		return (sv < 0) ? -int'(q) : int'(q);
	endfunction

	// wheel and pedal values for one sample under the current settings
	function automatic sdrc_out_t steering_outputs(sdrc_in_t s);
		int l;
		int r;
		int wh;
		sdrc_out_t o;
		l = shape_axis(s.left_axis, left_dz, linear_on);
		r = shape_axis(s.right_axis, right_dz, linear_on);
		wh = single_on ? l : (l + r) / 2;
		o.wheel = wh[AXIS_W-1:0];
		o.accel = {s.right_trigger, 8'h00};
		o.brake = {s.left_trigger, 8'h00};
		return o;
	endfunction

	// axis values biased toward extremes and deadzone edges
	function automatic logic signed [AXIS_W-1:0] pick_axis(int dz);
		int v;
		case ($urandom_range(0, 5))
			0, 1: v = int'($urandom_range(0, 65535)) - 32768;
			2: begin
				v = dz + int'($urandom_range(0, 6)) - 3;
				if ($urandom_range(0, 1))
					v = -v;
			end
			3: begin
				case ($urandom_range(0, 5))
					0: v = -32768;
					1: v = -32767;
					2: v = 32767;
					3: v = 0;
					4: v = -1;
					default: v = 1;
				endcase
			end
			4: v = int'($urandom_range(0, 64)) - 32;
			default: begin
				v = 32767 - int'($urandom_range(0, 200));
				if ($urandom_range(0, 1))
					v = -v - 1;
			end
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[AXIS_W-1:0];
	endfunction

	function automatic logic [DZ_W-1:0] pick_deadzone();
		case ($urandom_range(0, 5))
			0: return 15'd0;
			1: return 15'd32766;
			2: return 15'd32767;
			3: return 15'($urandom_range(1, 16));
			4: return 15'($urandom_range(1, 32765));
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	// result side: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 4);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result wheel=%0d accel=%h brake=%h", $time,
					result.wheel, result.accel, result.brake);
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (result.wheel !== want.wheel) begin
					$display("%0t: wheel expected %0d got %0d", $time, want.wheel,
						result.wheel);
					errors++;
				end
				if (result.accel !== want.accel) begin
					$display("%0t: accel expected %h got %h", $time, want.accel,
						result.accel);
					errors++;
				end
				if (result.brake !== want.brake) begin
					$display("%0t: brake expected %h got %h", $time, want.brake,
						result.brake);
					errors++;
				end
			end
		end
	end

	// offer one sample, hold it until taken, then record its expected result
	task automatic send_sample(input sdrc_in_t s, input bit known,
			input logic signed [AXIS_W-1:0] known_wheel);
		sdrc_out_t o;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		o = steering_outputs(s);
		if (known)
			o.wheel = known_wheel;
		pending_results.push_back(o);
		samples_sent++;
	endtask

	// stop offering samples and wait for every result in flight
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic reg_write(input sdrc_reg_t idx, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_LINEAR_MODE: linear_on = val[0];
			REG_SINGLE_STICK: single_on = val[0];
			REG_LEFT_DZ: left_dz = val[DZ_W-1:0];
			default: right_dz = val[DZ_W-1:0];
		endcase
		reg_writes++;
	endtask

	initial begin
		stick_case_t row;
		sdrc_in_t s;
		int phase;
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		gaps_on = 1'b1;
		for (n = 0; n < N_DIRECTED; n++) begin
			row = stick_cases[n];
			if (row.lin != linear_on || row.single != single_on || row.ldz != left_dz ||
					row.rdz != right_dz) begin
				drain();
				if (row.lin != linear_on)
					reg_write(REG_LINEAR_MODE, 32'(row.lin));
				if (row.single != single_on)
					reg_write(REG_SINGLE_STICK, 32'(row.single));
				if (row.ldz != left_dz)
					reg_write(REG_LEFT_DZ, 32'(row.ldz));
				if (row.rdz != right_dz)
					reg_write(REG_RIGHT_DZ, 32'(row.rdz));
			end
			s.left_axis = row.left;
			s.right_axis = row.right;
			s.left_trigger = row.ltrig;
			s.right_trigger = row.rtrig;
			send_sample(s, row.known, row.wheel);
		end

		// random phases, each under fresh settings; the last runs without idling
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			gaps_on = (phase < PHASES - 1) && ($urandom_range(0, 3) != 0);
			reg_write(REG_LINEAR_MODE, 32'($urandom_range(0, 1)));
			reg_write(REG_SINGLE_STICK, 32'($urandom_range(0, 1)));
			reg_write(REG_LEFT_DZ, 32'(pick_deadzone()));
			reg_write(REG_RIGHT_DZ, 32'(pick_deadzone()));
			for (n = 0; n < PHASE_SAMPLES; n++) begin
				s.left_axis = pick_axis(left_dz);
				s.right_axis = pick_axis(right_dz);
				s.left_trigger = 8'($urandom_range(0, 255));
				s.right_trigger = 8'($urandom_range(0, 255));
				send_sample(s, 1'b0, '0);
			end
		end

		drain();
		repeat (30) @(posedge clk);
		$display("covered %0d samples, %0d results compared, %0d register writes",
			samples_sent, results_checked, reg_writes);
		$display("curve and linear modes, single and averaged wheel, deadzones 0 to full");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
